### design/tli_pkg.sv
// Shared types, constants and sequencer states for the table Lagrange interpolator.
// Used by table_lagrange_interpolator_core; depends on nothing else.
package tli_pkg;

   localparam int TABLE_POINTS = 15;
   localparam int GRID_STEP    = 10;
   localparam int HIGH_HEAD    = 8;
   localparam int LOW_TAIL     = 10;
   localparam int WINDOW_SPLIT = TABLE_POINTS * (10 / 2);
   // s / 10 == (s * 205) >> 11 for every 8-bit s
   localparam int RECIP_MUL    = 205;
   localparam int RECIP_SHIFT  = 11;

   typedef struct packed {
      logic        func;
      logic [3:0]  point_index;
      logic [7:0]  point_x;
      logic [23:0] point_y;
      logic [7:0]  setting;
   } req_item_type;

   typedef struct packed {
      logic [30:0] value;
      logic        fell_back;
      logic        fault;
   } rsp_item_type;

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_RD_I,
      ST_LD_I,
      ST_NEXT_J,
      ST_GET_J,
      ST_MUL,
      ST_DIV_LD,
      ST_DIV,
      ST_DIV_END,
      ST_BR_LO,
      ST_BR_HI,
      ST_BR_CMP,
      ST_FINISH,
      ST_DONE
   } tli_state_type;

endpackage

### design/table_lagrange_interpolator_core.sv
// Table Lagrange interpolator: point table, sequencer, shared multiplier and divider.
// Depends on tli_pkg.
// For a write, rsp_valid is raised in the cycle after the accepting edge. A query runs
// each basis factor through the multiplier and a two-bit-per-cycle divider, over the low
// window or the high one, then may add the bracket check and the linear fallback; a
// fault ends early.
// busy stays high through the rsp_valid cycle; the next beat is accepted once the sequencer is back in idle.
// Reset (synchronous) returns the sequencer to idle; the point table is not cleared.
module table_lagrange_interpolator_core
   import tli_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         start,
   output logic         busy,
   input  req_item_type req_item,
   output logic         rsp_valid,
   output rsp_item_type rsp_item
);

   localparam logic [63:0] I64_MAX = {1'b0, {63{1'b1}}};
   localparam logic [63:0] I64_MIN = {1'b1, {63{1'b0}}};

   tli_state_type state_ff, state_in;

   logic [31:0] pts_mem [TABLE_POINTS];
   logic [31:0] rd_data_ff;
   logic [3:0]  rd_addr;

   logic [7:0]  s_ff;
   logic [3:0]  head_ff, tail_ff, i_ff, j_ff, kl_ff, kh_ff;
   logic [3:0]  frac_ff;
   logic [7:0]  xi_ff;
   logic [63:0] term_ff, sum_ff, quo_ff;
   logic [8:0]  m_ff, d_ff;
   logic [7:0]  rem_ff;
   logic        neg_ff, fb_ff;
   logic [4:0]  cnt_ff;
   logic [30:0] value_ff;
   logic        fell_ff, fault_ff;
   logic [23:0] lo_ff;

   logic        accept;
   logic [7:0]  xj;
   logic [8:0]  d_now;
   logic [15:0] recip;
   logic [4:0]  k_now;
   logic [4:0]  k1_now;
   logic [3:0]  kl_now, kh_now;
   logic [7:0]  frac_now;

   assign accept = start && !busy;
   assign xj     = rd_data_ff[31:24];
   assign d_now  = {1'b0, xi_ff} - {1'b0, xj};

   // bracket index and offset on the grid
   assign recip    = req_item.setting * 16'(RECIP_MUL);
   assign k_now    = recip[15:RECIP_SHIFT];
   assign k1_now   = k_now + 5'd1;
   assign kl_now   = (k_now > 5'(TABLE_POINTS - 1)) ? 4'(TABLE_POINTS - 1) : k_now[3:0];
   assign kh_now   = (k1_now > 5'(TABLE_POINTS - 1)) ? 4'(TABLE_POINTS - 1) : k1_now[3:0];
   assign frac_now = req_item.setting - 8'(k_now) * 8'(GRID_STEP);

   // saturating multiply of term_ff by the signed 9-bit factor m_ff
   logic        mul_neg;
   logic [63:0] mul_mag, mul_res;
   logic [7:0]  mul_mm;
   logic [71:0] mul_p, mul_lim;
   always_comb begin
      mul_neg = (term_ff[63] != m_ff[8]) && (term_ff != '0) && (m_ff != '0);
      mul_mag = term_ff[63] ? (64'd0 - term_ff) : term_ff;
      mul_mm  = m_ff[8] ? 8'(9'd0 - m_ff) : m_ff[7:0];
      mul_p   = mul_mag * mul_mm;
      mul_lim = mul_neg ? {8'd0, I64_MIN} : {8'd0, I64_MAX};
      if (mul_p > mul_lim) mul_p = mul_lim;
      mul_res = mul_neg ? (64'd0 - mul_p[63:0]) : mul_p[63:0];
   end

   // two restoring divide steps per cycle
   logic [8:0]  dv_r0, dv_r1;
   logic [7:0]  dv_dm, dv_rem_a;
   logic [63:0] dv_q_a, dv_q_b;
   logic [7:0]  dv_rem_b;
   always_comb begin
      dv_dm = d_ff[8] ? 8'(9'd0 - d_ff) : d_ff[7:0];
      dv_r0 = {rem_ff, quo_ff[63]};
      if (dv_r0 >= {1'b0, dv_dm}) begin
         dv_rem_a = 8'(dv_r0 - {1'b0, dv_dm});
         dv_q_a   = {quo_ff[62:0], 1'b1};
      end else begin
         dv_rem_a = dv_r0[7:0];
         dv_q_a   = {quo_ff[62:0], 1'b0};
      end
      dv_r1 = {dv_rem_a, dv_q_a[63]};
      if (dv_r1 >= {1'b0, dv_dm}) begin
         dv_rem_b = 8'(dv_r1 - {1'b0, dv_dm});
         dv_q_b   = {dv_q_a[62:0], 1'b1};
      end else begin
         dv_rem_b = dv_r1[7:0];
         dv_q_b   = {dv_q_a[62:0], 1'b0};
      end
   end

   logic [63:0] div_res;
   always_comb begin
      if (!neg_ff && quo_ff[63]) div_res = I64_MAX;
      else if (neg_ff) div_res = 64'd0 - quo_ff;
      else div_res = quo_ff;
   end

   // saturating accumulate
   logic [64:0] add_w;
   logic [63:0] add_res;
   always_comb begin
      add_w = {sum_ff[63], sum_ff} + {term_ff[63], term_ff};
      if (add_w[64] != add_w[63]) add_res = add_w[64] ? I64_MIN : I64_MAX;
      else add_res = add_w[63:0];
   end

   logic [23:0] hi_y;
   logic        out_of_bracket;
   assign hi_y = rd_data_ff[23:0];
   assign out_of_bracket = $signed(sum_ff) < $signed({40'd0, lo_ff})
                        || $signed(sum_ff) > $signed({40'd0, hi_y});

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (accept) state_in = req_item.func ? ST_RD_I : ST_DONE;
         end
         ST_RD_I:   state_in = ST_LD_I;
         ST_LD_I:   state_in = ST_NEXT_J;
         ST_NEXT_J: begin
            if (j_ff == tail_ff) begin
               if (i_ff + 4'd1 != tail_ff) state_in = ST_RD_I;
               else if (frac_ff != '0) state_in = ST_BR_LO;
               else state_in = ST_FINISH;
            end else if (j_ff != i_ff) begin
               state_in = ST_GET_J;
            end
         end
         ST_GET_J:   state_in = (d_now == '0) ? ST_DONE : ST_MUL;
         ST_MUL:     state_in = ST_DIV_LD;
         ST_DIV_LD:  state_in = ST_DIV;
         ST_DIV:     if (cnt_ff == '1) state_in = ST_DIV_END;
         ST_DIV_END: state_in = fb_ff ? ST_FINISH : ST_NEXT_J;
         ST_BR_LO:   state_in = ST_BR_HI;
         ST_BR_HI:   state_in = ST_BR_CMP;
         ST_BR_CMP:  state_in = out_of_bracket ? ST_MUL : ST_FINISH;
         ST_FINISH:  state_in = ST_DONE;
         ST_DONE:    state_in = ST_IDLE;
         default:    state_in = ST_IDLE;
      endcase
   end

   // outputs and table read address
   always_comb begin
      busy      = (state_ff != ST_IDLE);
      rsp_valid = (state_ff == ST_DONE);
      case (state_ff)
         ST_NEXT_J: rd_addr = j_ff;
         ST_BR_LO:  rd_addr = kl_ff;
         ST_BR_HI:  rd_addr = kh_ff;
         default:   rd_addr = i_ff;
      endcase
   end

   assign rsp_item.value     = value_ff;
   assign rsp_item.fell_back = fell_ff;
   assign rsp_item.fault     = fault_ff;

   always_ff @(posedge clock) begin
      if (reset) state_ff <= ST_IDLE;
      else state_ff <= state_in;
   end

   always_ff @(posedge clock) begin
      rd_data_ff <= pts_mem[rd_addr];
      if (accept && !req_item.func && req_item.point_index < 4'(TABLE_POINTS))
         pts_mem[req_item.point_index] <= {req_item.point_x, req_item.point_y};
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         ST_IDLE: begin
            s_ff     <= req_item.setting;
            kl_ff    <= kl_now;
            kh_ff    <= kh_now;
            frac_ff  <= frac_now[3:0];
            sum_ff   <= '0;
            fb_ff    <= 1'b0;
            value_ff <= '0;
            fell_ff  <= 1'b0;
            fault_ff <= 1'b0;
            if (req_item.setting > 8'(WINDOW_SPLIT)) begin
               head_ff <= 4'(HIGH_HEAD);
               tail_ff <= 4'(TABLE_POINTS);
               i_ff    <= 4'(HIGH_HEAD);
            end else begin
               head_ff <= '0;
               tail_ff <= 4'(LOW_TAIL);
               i_ff    <= '0;
            end
         end
         ST_LD_I: begin
            xi_ff   <= rd_data_ff[31:24];
            term_ff <= {40'd0, rd_data_ff[23:0]};
            j_ff    <= head_ff;
         end
         ST_NEXT_J: begin
            if (j_ff == tail_ff) begin
               sum_ff <= add_res;
               i_ff   <= i_ff + 4'd1;
            end else if (j_ff == i_ff) begin
               j_ff <= j_ff + 4'd1;
            end
         end
         ST_GET_J: begin
            d_ff     <= d_now;
            m_ff     <= {1'b0, s_ff} - {1'b0, xj};
            fault_ff <= (d_now == '0);
         end
         ST_MUL: term_ff <= mul_res;
         ST_DIV_LD: begin
            quo_ff <= term_ff[63] ? (64'd0 - term_ff) : term_ff;
            neg_ff <= term_ff[63] ^ d_ff[8];
            rem_ff <= '0;
            cnt_ff <= '0;
         end
         ST_DIV: begin
            quo_ff <= dv_q_b;
            rem_ff <= dv_rem_b;
            cnt_ff <= cnt_ff + 5'd1;
         end
         ST_DIV_END: begin
            if (fb_ff) begin
               sum_ff <= {40'd0, lo_ff} + div_res;
            end else begin
               term_ff <= div_res;
               j_ff    <= j_ff + 4'd1;
            end
         end
         ST_BR_HI: lo_ff <= rd_data_ff[23:0];
         ST_BR_CMP: begin
            // drop to linear interpolation on the grid
            if (out_of_bracket) begin
               term_ff <= {40'd0, hi_y} - {40'd0, lo_ff};
               m_ff    <= {5'd0, frac_ff};
               d_ff    <= 9'(GRID_STEP);
               fb_ff   <= 1'b1;
            end
         end
         ST_FINISH: begin
            fell_ff <= fb_ff;
            if (sum_ff[63]) value_ff <= '0;
            else if (sum_ff[62:31] != '0) value_ff <= '1;
            else value_ff <= sum_ff[30:0];
         end
         default: ;
      endcase
   end

   a_strobe_single: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |=> !rsp_valid) else $error("result strobe longer than one cycle");

   a_fault_clean: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_item.fault |-> !rsp_item.fell_back && rsp_item.value == '0)
      else $error("fault beat carries a value");

   a_busy_after_start: assert property (@(posedge clock) disable iff (reset)
      accept |=> busy) else $error("busy not raised after accepted beat");

   a_div_bounded: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_DIV |-> rem_ff < dv_dm) else $error("divider remainder out of range");

endmodule
